>>> rtl/rtd_pkg.sv
// Package for the integer-to-radix-digits block: widths, register map,
// shared config and state types. Used by every module in rtl/; depends on nothing.
package rtd_pkg;

    localparam int VALUE_W    = 64;
    localparam int RADIX_W    = 9;
    localparam int COUNT_W    = 7;
    localparam int DIGIT_W    = 8;
    localparam int COLUMN_W   = 6;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam int DEFAULT_MAX_DIGITS = 64;

    // Divider retires this many dividend bits per cycle.
    localparam int STEP_BITS  = 8;
    localparam int STEPS      = VALUE_W / STEP_BITS;
    localparam int STEP_CNT_W = $clog2(STEPS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(256);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(2);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);

    typedef enum logic [1:0] {
        REG_RADIX     = 2'd0,
        REG_COUNT     = 2'd1,
        REG_MSB_FIRST = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    // Effective (clamped) configuration seen by the back end.
    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [COUNT_W-1:0] count;
        logic               msb_first;
    } cfg_t;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_DIVIDE = 2'd1,
        BK_HOLD   = 2'd2
    } back_state_t;

endpackage

>>> rtl/rtd_front.sv
// Front end: APB register file with clamping to the effective config,
// and acceptance of input beats toward the queue. Depends on rtd_pkg.
module rtd_front #(
    parameter int MAX_DIGITS = rtd_pkg::DEFAULT_MAX_DIGITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rtd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rtd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rtd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rtd_pkg::VALUE_W-1:0]         value,
    output logic                                push_valid,
    input  logic                                push_ready,
    output logic [rtd_pkg::VALUE_W-1:0]         push_value,
    output rtd_pkg::cfg_t                       cfg
);

    localparam logic [rtd_pkg::COUNT_W-1:0] COUNT_MAX = rtd_pkg::COUNT_W'(MAX_DIGITS);

    logic [rtd_pkg::RADIX_W-1:0] radix_reg;
    logic [rtd_pkg::COUNT_W-1:0] count_reg;
    logic                        msb_first_reg;
    logic                        wr_en;
    rtd_pkg::reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = rtd_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= rtd_pkg::RADIX_RESET;
            count_reg     <= rtd_pkg::COUNT_RESET;
            msb_first_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (idx)
                rtd_pkg::REG_RADIX:     radix_reg     <= pwdata[rtd_pkg::RADIX_W-1:0];
                rtd_pkg::REG_COUNT:     count_reg     <= pwdata[rtd_pkg::COUNT_W-1:0];
                rtd_pkg::REG_MSB_FIRST: msb_first_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            rtd_pkg::REG_RADIX:     prdata = rtd_pkg::APB_DATA_W'(radix_reg);
            rtd_pkg::REG_COUNT:     prdata = rtd_pkg::APB_DATA_W'(count_reg);
            rtd_pkg::REG_MSB_FIRST: prdata = rtd_pkg::APB_DATA_W'(msb_first_reg);
            default:                prdata = '0;
        endcase
    end

    // Clamp register values to the usable range.
    always_comb
    begin
        if (radix_reg < rtd_pkg::RADIX_MIN)
            cfg.radix = rtd_pkg::RADIX_MIN;
        else if (radix_reg > rtd_pkg::RADIX_MAX)
            cfg.radix = rtd_pkg::RADIX_MAX;
        else
            cfg.radix = radix_reg;

        if (count_reg == '0)
            cfg.count = rtd_pkg::COUNT_W'(1);
        else if (count_reg > COUNT_MAX)
            cfg.count = COUNT_MAX;
        else
            cfg.count = count_reg;

        cfg.msb_first = msb_first_reg;
    end

    assign push_valid = in_valid;
    assign push_value = value;
    assign in_ready   = push_ready;

endmodule

>>> rtl/rtd_queue.sv
// Short FIFO between front and back ends holding accepted values.
// Depends on rtd_pkg for width and depth.
module rtd_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_valid,
    output logic                        wr_ready,
    input  logic [rtd_pkg::VALUE_W-1:0] wr_data,
    output logic                        rd_valid,
    input  logic                        rd_ready,
    output logic [rtd_pkg::VALUE_W-1:0] rd_data
);

    logic [rtd_pkg::VALUE_W-1:0] slot_reg [rtd_pkg::QUEUE_DEPTH];
    logic [rtd_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [rtd_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [rtd_pkg::QCNT_W-1:0]  cnt_reg;
    logic                        push;
    logic                        pop;

    assign wr_ready = cnt_reg != rtd_pkg::QCNT_W'(rtd_pkg::QUEUE_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == rtd_pkg::QPTR_W'(rtd_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == rtd_pkg::QPTR_W'(rtd_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

>>> rtl/rtd_back.sv
// Back end: iterative divider (eight dividend bits per cycle) producing one
// digit per pass, plus the output register. Depends on rtd_pkg.
module rtd_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rtd_pkg::cfg_t                cfg,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  logic [rtd_pkg::VALUE_W-1:0]  q_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rtd_pkg::DIGIT_W-1:0]  digit,
    output logic [rtd_pkg::COLUMN_W-1:0] column,
    output logic                         last_digit
);

    rtd_pkg::back_state_t state_reg, state_next;

    logic [rtd_pkg::VALUE_W-1:0]    work_reg, work_next;
    logic [rtd_pkg::DIGIT_W-1:0]    rem_reg, rem_next;
    logic [rtd_pkg::STEP_CNT_W-1:0] step_reg, step_next;
    logic [rtd_pkg::COLUMN_W-1:0]   idx_reg, idx_next;

    logic                           out_valid_reg;
    logic [rtd_pkg::DIGIT_W-1:0]    digit_reg;
    logic [rtd_pkg::COLUMN_W-1:0]   column_reg;
    logic                           last_reg;

    logic [rtd_pkg::VALUE_W-1:0]    w_step;
    logic [rtd_pkg::RADIX_W-1:0]    r_step;
    logic                           last_step;
    logic                           slot_free;
    logic                           is_last;
    logic                           load_out;
    logic [rtd_pkg::DIGIT_W-1:0]    out_digit;
    logic [rtd_pkg::COUNT_W-1:0]    last_idx;
    logic [rtd_pkg::COUNT_W-1:0]    mirror;

    // Eight restoring-division steps: shift dividend bits into the remainder,
    // subtract the radix when it fits, shift the quotient bit in at the bottom.
    always_comb
    begin
        w_step = work_reg;
        r_step = rtd_pkg::RADIX_W'(rem_reg);
        for (int k = 0; k < rtd_pkg::STEP_BITS; k++)
        begin
            r_step = {r_step[rtd_pkg::RADIX_W-2:0], w_step[rtd_pkg::VALUE_W-1]};
            w_step = {w_step[rtd_pkg::VALUE_W-2:0], 1'b0};
            if (r_step >= cfg.radix)
            begin
                r_step    = r_step - cfg.radix;
                w_step[0] = 1'b1;
            end
        end
    end

    assign last_step = step_reg == rtd_pkg::STEP_CNT_W'(rtd_pkg::STEPS - 1);
    assign slot_free = !out_valid_reg || out_ready;
    assign last_idx  = cfg.count - 1'b1;
    assign is_last   = rtd_pkg::COUNT_W'(idx_reg) == last_idx;
    assign mirror    = last_idx - rtd_pkg::COUNT_W'(idx_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtd_pkg::BK_IDLE:
                if (q_valid)
                    state_next = rtd_pkg::BK_DIVIDE;
            rtd_pkg::BK_DIVIDE:
                if (last_step)
                begin
                    if (!slot_free)
                        state_next = rtd_pkg::BK_HOLD;
                    else if (is_last)
                        state_next = rtd_pkg::BK_IDLE;
                end
            rtd_pkg::BK_HOLD:
                if (slot_free)
                    state_next = is_last ? rtd_pkg::BK_IDLE : rtd_pkg::BK_DIVIDE;
            default:
                state_next = rtd_pkg::BK_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        q_ready   = 1'b0;
        load_out  = 1'b0;
        out_digit = r_step[rtd_pkg::DIGIT_W-1:0];
        case (state_reg)
            rtd_pkg::BK_IDLE:
                q_ready = 1'b1;
            rtd_pkg::BK_DIVIDE:
                load_out = last_step && slot_free;
            rtd_pkg::BK_HOLD:
            begin
                load_out  = slot_free;
                out_digit = rem_reg;
            end
            default: ;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        idx_next  = idx_reg;
        case (state_reg)
            rtd_pkg::BK_IDLE:
            begin
                work_next = q_value;
                rem_next  = '0;
                step_next = '0;
                idx_next  = '0;
            end
            rtd_pkg::BK_DIVIDE:
            begin
                work_next = w_step;
                rem_next  = r_step[rtd_pkg::DIGIT_W-1:0];
                step_next = step_reg + 1'b1;
                if (load_out)
                begin
                    rem_next = '0;
                    idx_next = idx_reg + 1'b1;
                end
            end
            rtd_pkg::BK_HOLD:
                if (load_out)
                begin
                    rem_next = '0;
                    idx_next = idx_reg + 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtd_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        idx_reg  <= idx_next;
        if (load_out)
        begin
            digit_reg  <= out_digit;
            column_reg <= cfg.msb_first ? mirror[rtd_pkg::COLUMN_W-1:0] : idx_reg;
            last_reg   <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit      = digit_reg;
    assign column     = column_reg;
    assign last_digit = last_reg;

endmodule

>>> rtl/integer_to_radix_digits.sv
// Top level of the integer-to-radix-digits block: front end, queue, back end.
// Depends on rtd_pkg, rtd_front, rtd_queue and rtd_back.
//
//  channel   handshake               payload                     direction
//  -------   ---------------------   -------------------------   ---------
//  input     in_valid / in_ready     value[63:0]                 in
//  result    out_valid / out_ready   digit, column, last_digit   out
//  config    APB psel/penable/pready paddr[3:0], pwdata, prdata  in/out
//
// Each digit takes one pass of the back-end divider over the 64-bit value (8
// dividend bits per cycle while it divides), so a value with n digits occupies
// it for n passes plus a pickup of the next value from the idle state.
// Reset (rst_n low, asynchronous) empties the queue, drops any value in flight,
// and loads radix 2, digit count 8, LSB-first columns.
// The two-entry queue keeps taking values while the divider works; a stalled
// result beat holds in the output register and the divider waits only when it
// finishes the next digit with the register still full.
module integer_to_radix_digits #(
    parameter int MAX_DIGITS = rtd_pkg::DEFAULT_MAX_DIGITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rtd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rtd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rtd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rtd_pkg::VALUE_W-1:0]    value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rtd_pkg::DIGIT_W-1:0]    digit,
    output logic [rtd_pkg::COLUMN_W-1:0]   column,
    output logic                           last_digit
);

    rtd_pkg::cfg_t               cfg;
    logic                        push_valid;
    logic                        push_ready;
    logic [rtd_pkg::VALUE_W-1:0] push_value;
    logic                        q_valid;
    logic                        q_ready;
    logic [rtd_pkg::VALUE_W-1:0] q_value;

    // Register file and input acceptance.
    rtd_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_value (push_value),
        .cfg        (cfg)
    );

    // Hold accepted values until the divider is free.
    rtd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_value),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_value)
    );

    // Divide out one digit per pass and emit result beats.
    rtd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_value    (q_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit      (digit),
        .column     (column),
        .last_digit (last_digit)
    );

endmodule
